>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define EPE_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// clocked assertion that also holds across reset
`define EPE_ASSERT_NR(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

>>> sv/epe_pkg.sv
// shared types and constants of the exclusion probability estimator
`timescale 1ns / 1ps

package epe_pkg;

  localparam int PROB_W     = 17;
  localparam int POS_W      = 4;
  localparam int SLOT_W     = 5;
  localparam int SLOTS      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam logic [PROB_W-1:0] PROB_ONE   = 17'd65536;
  localparam logic [PROB_W-1:0] PROB_CLAMP = 17'd55706;
  localparam logic [PROB_W-1:0] PROB_ZERO  = 17'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_INTERVAL = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_SPEC     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_REG      = 8'd3;

  // configuration reset values
  localparam logic [15:0]         RST_WINDOW_SIZE    = 16'd100;
  localparam logic [15:0]         RST_CLAMP_INTERVAL = 16'd100;
  localparam logic [PROB_W-1:0]   RST_DELTA          = 17'd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CLAMP,
    ST_READ_REG,
    ST_PROB,
    ST_MUL_MISS,
    ST_MUL_PROB,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } epe_state_t;

endpackage

>>> sv/exclusion_probability_estimator.sv
// top level of the exclusion probability estimator
// Takes one completed request per input beat (tuser: is_regular; tdata: pos_count, was_miss)
// and returns one result beat per request (tuser: estimate_updated, clamped; tdata:
// exclusion_prob in Q1.16, 65536 meaning one). Requests are handled one at a time; a regular
// request needs a second read of the probability ram. A request that completes a window
// adds two multiply steps, the rounded divide by window_size, with the divider retiring two
// quotient bits per cycle, and a write-back. The per-slot request and miss counters sit in
// one ram, the probabilities in another, whose speculative entries also hold the per-count
// clamp counter; both rams have one port, so the steps of a request are sequenced. Ram
// entries carry valid bits cleared by reset, so no clearing pass is needed. The output
// register frees the input side while a result waits to be taken. Configuration writes
// are always taken, and are meant to be issued only while the block is idle.
`timescale 1ns / 1ps

module exclusion_probability_estimator #(
  parameter int MAX_CACHES  = 15,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [3:0] pos_count, [4] was_miss, rest zero
  input  logic        s_tuser,    // [0] is_regular
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [16:0] exclusion_prob, rest zero
  output logic [1:0]  m_tuser,    // [0] estimate_updated, [1] clamped
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [epe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [epe_pkg::CFG_DATA_W-1:0] cfg_data
);

  import epe_pkg::*;

  localparam int CW    = COUNT_WIDTH;
  localparam int AW    = 2 * CW;             // request count, miss count
  localparam int BW    = PROB_W + CW;        // probability, clamp count
  localparam int CMPW  = (CW > 16) ? CW : 16;
  localparam int DW    = CW + PROB_W + 1;    // delta*misses + window/2
  localparam int DWE   = DW + (DW % 2);      // even, two bits per divide cycle
  localparam int ITER  = DWE / 2;
  localparam int IW    = $clog2(ITER + 1);
  localparam logic [7:0] MAXC = 8'(MAX_CACHES);

  // configuration registers
  logic [15:0]       window_size;
  logic [15:0]       clamp_interval;
  logic [PROB_W-1:0] delta_spec;
  logic [PROB_W-1:0] delta_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= RST_WINDOW_SIZE;
      clamp_interval <= RST_CLAMP_INTERVAL;
      delta_spec     <= RST_DELTA;
      delta_reg      <= RST_DELTA;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_SIZE:    window_size    <= cfg_data[15:0];
        CFG_CLAMP_INTERVAL: clamp_interval <= cfg_data[15:0];
        CFG_DELTA_SPEC:     delta_spec     <= cfg_data;
        CFG_DELTA_REG:      delta_reg      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state
  epe_state_t state, state_next;

  // latched request
  logic             item_reg;
  logic [POS_W-1:0] item_pos;
  logic             item_miss;
  logic [SLOT_W-1:0] slot;

  // working registers
  logic [CW-1:0]     req_n;
  logic [CW-1:0]     miss_n;
  logic              win_hit;
  logic              clamp_hit;
  logic [PROB_W-1:0] prob_cur;
  logic [CW-1:0]     slot_clamp;
  logic [PROB_W-1:0] delta_q;
  logic [PROB_W+CW-1:0] p1;
  logic [PROB_W-1:0] t2;
  logic [DWE-1:0]    dividend;
  logic [15:0]       rem;
  logic [DWE-1:0]    quo;
  logic [IW-1:0]     iter;

  // pending result
  logic              res_upd;
  logic              res_clamp;
  logic [PROB_W-1:0] res_prob;

  // output register
  logic              out_valid;
  logic              out_upd;
  logic              out_clamp;
  logic [PROB_W-1:0] out_prob;

  // ram ports
  logic              a_we, b_we;
  logic [SLOT_W-1:0] a_addr, b_addr;
  logic [AW-1:0]     a_wdata, a_rdata, a_eff;
  logic [BW-1:0]     b_wdata, b_rdata, b_eff;

  // entry valid bits; an entry never written reads as its reset value
  logic [SLOTS-1:0]  a_valid, b_valid;
  logic              a_rv, b_rv, b_rmsb;

  epe_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_cnt_ram (
    .clk   (clk),
    .we    (a_we),
    .addr  (a_addr),
    .wdata (a_wdata),
    .rdata (a_rdata)
  );

  epe_ram #(.WIDTH(BW), .DEPTH(SLOTS)) u_prob_ram (
    .clk   (clk),
    .we    (b_we),
    .addr  (b_addr),
    .wdata (b_wdata),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= '0;
      b_valid <= '0;
      a_rv    <= 1'b0;
      b_rv    <= 1'b0;
      b_rmsb  <= 1'b0;
    end else begin
      a_rv   <= a_valid[a_addr];
      b_rv   <= b_valid[b_addr];
      b_rmsb <= b_addr[SLOT_W-1];
      if (a_we) begin
        a_valid[a_addr] <= 1'b1;
      end
      if (b_we) begin
        b_valid[b_addr] <= 1'b1;
      end
    end
  end

  // speculative entries reset to the clamp value, regular entries to zero
  assign a_eff = a_rv ? a_rdata : '0;
  assign b_eff = b_rv ? b_rdata : {(b_rmsb ? PROB_ZERO : PROB_CLAMP), {CW{1'b0}}};

  assign slot     = {item_reg, item_pos};
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_prob};
  assign m_tuser  = {out_clamp, out_upd};

  // request after count saturation
  logic [POS_W-1:0] pos_in;
  assign pos_in = ({4'd0, s_tdata[3:0]} > MAXC) ? MAXC[POS_W-1:0] : s_tdata[3:0];

  // clamp step
  logic [CW-1:0]     req_inc, miss_inc, cl_cnt, cl_wr;
  logic              cl_hit, wn_hit;
  logic [PROB_W-1:0] prob_pos, prob_rd;

  // re-estimation datapath
  logic [PROB_W-1:0] delta_sel, delta_sat;
  logic [PROB_W-1:0] one_minus;
  logic [33:0]       t2_full;
  logic [16:0]       trial1, trial2;
  logic [15:0]       rem1, rem2;
  logic              qb1, qb2;
  logic [DWE:0]      sum;
  logic [PROB_W-1:0] prob_new;
  logic              out_free;

  always_comb begin
    req_inc  = a_eff[AW-1:CW] + CW'(1);
    miss_inc = a_eff[CW-1:0] + CW'(item_miss);
    cl_cnt   = b_eff[CW-1:0] + CW'(!item_reg);
    cl_hit   = (clamp_interval != 16'd0) &&
               (CMPW'(cl_cnt) == CMPW'(clamp_interval));
    wn_hit   = (window_size != 16'd0) && (CMPW'(req_inc) == CMPW'(window_size));
    prob_rd  = b_eff[BW-1:CW];
    prob_pos = (cl_hit && (prob_rd > PROB_CLAMP)) ? PROB_CLAMP : prob_rd;
    cl_wr    = cl_hit ? '0 : cl_cnt;

    delta_sel = item_reg ? delta_reg : delta_spec;
    delta_sat = (delta_sel > PROB_ONE) ? PROB_ONE : delta_sel;
    one_minus = PROB_ONE - delta_q;
    t2_full   = 34'(one_minus) * 34'(prob_cur) + 34'd32768;

    // two restoring divide steps
    trial1 = {rem, dividend[DWE-1]};
    qb1    = (trial1 >= {1'b0, window_size});
    rem1   = qb1 ? 16'(trial1 - {1'b0, window_size}) : trial1[15:0];
    trial2 = {rem1, dividend[DWE-2]};
    qb2    = (trial2 >= {1'b0, window_size});
    rem2   = qb2 ? 16'(trial2 - {1'b0, window_size}) : trial2[15:0];

    sum      = {1'b0, quo} + (DWE+1)'(t2);
    prob_new = (sum > (DWE+1)'(PROB_ONE)) ? PROB_ONE : sum[PROB_W-1:0];

    out_free = !out_valid || m_tready;

    state_next = state;
    a_we    = 1'b0;
    a_addr  = slot;
    a_wdata = {req_n, miss_n};
    b_we    = 1'b0;
    b_addr  = slot;
    b_wdata = {prob_new, slot_clamp};

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        b_addr     = {1'b0, item_pos};
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        // speculative entry of this count: clamp counter and clamp
        b_we       = 1'b1;
        b_addr     = {1'b0, item_pos};
        b_wdata    = {prob_pos, cl_wr};
        state_next = item_reg ? ST_READ_REG : ST_PROB;
      end
      ST_READ_REG: begin
        state_next = ST_PROB;
      end
      ST_PROB: begin
        if (win_hit) begin
          state_next = ST_MUL_MISS;
        end else begin
          a_we       = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_MUL_MISS: begin
        state_next = ST_MUL_PROB;
      end
      ST_MUL_PROB: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (iter == IW'(ITER - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // window closed: both counters cleared, new estimate stored
        a_we       = 1'b1;
        a_wdata    = '0;
        b_we       = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        item_reg  <= s_tuser;
        item_pos  <= pos_in;
        item_miss <= s_tdata[4];
      end
      ST_CLAMP: begin
        req_n      <= req_inc;
        miss_n     <= miss_inc;
        win_hit    <= wn_hit;
        clamp_hit  <= cl_hit;
        prob_cur   <= prob_pos;
        slot_clamp <= cl_wr;
      end
      ST_PROB: begin
        // a regular slot's probability comes from its own entry
        if (item_reg) begin
          prob_cur   <= prob_rd;
          slot_clamp <= b_eff[CW-1:0];
        end
        delta_q   <= delta_sat;
        res_upd   <= 1'b0;
        res_clamp <= clamp_hit;
        res_prob  <= item_reg ? prob_rd : prob_cur;
      end
      ST_MUL_MISS: begin
        p1 <= delta_q * miss_n;
      end
      ST_MUL_PROB: begin
        t2       <= t2_full[32:16];
        dividend <= DWE'(p1) + DWE'(window_size[15:1]);
        rem      <= '0;
        quo      <= '0;
        iter     <= '0;
      end
      ST_DIV: begin
        dividend <= {dividend[DWE-3:0], 2'b00};
        rem      <= rem2;
        quo      <= {quo[DWE-3:0], qb1, qb2};
        iter     <= iter + IW'(1);
      end
      ST_FIN: begin
        res_upd  <= 1'b1;
        res_prob <= prob_new;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_upd   <= res_upd;
      out_clamp <= res_clamp;
      out_prob  <= res_prob;
    end
  end

endmodule

>>> sv/epe_ram.sv
// generic single-port synchronous ram with registered read
`timescale 1ns / 1ps

module epe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/epe_checker.sv
// port-level checker of the exclusion probability estimator and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module epe_port_assert (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [7:0]  cfg_index,
  input logic [16:0] cfg_data
);

  // a stalled result beat holds
  `EPE_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // probability never above one, padding zero
  `EPE_ASSERT(a_range, clk, rst, m_tvalid |-> m_tdata[23:17] == 7'd0 && m_tdata[16:0] <= 17'd65536, "probability out of range")

  // one request in flight at a time
  `EPE_ASSERT(a_single, clk, rst, s_tvalid && s_tready |=> !s_tready, "request taken while one is in flight")

  // reset empties the output register
  `EPE_ASSERT_NR(a_reset, clk, rst |=> !m_tvalid, "result beat right after reset")

endmodule

bind exclusion_probability_estimator epe_port_assert u_epe_port_assert (.*);
